// ----- rtl/core/rvx_pkg.sv -----
// Shared types and constants of the RV64IM integer execute unit.
package rvx_pkg;

	localparam int XLEN = 64;
	localparam int DIV_STAGES = XLEN;
	localparam int CTL_STAGES = DIV_STAGES + 1;
	localparam int OUT_STAGE = CTL_STAGES + 1;

	localparam logic [6:0] OPC_OP = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_OP_32 = 7'h3b;
	localparam logic [6:0] OPC_OP_IMM_32 = 7'h1b;
	localparam logic [6:0] OPC_LUI = 7'h37;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_JAL = 7'h6f;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT = 7'h20;
	localparam logic [5:0] F6_BASE = 6'h00;
	localparam logic [5:0] F6_ALT = 6'h10;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR = 3'd5;
	localparam logic [2:0] F3_OR = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;

	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LOAD_BAD = 3'd7;
	localparam logic [2:0] F3_STORE_MAX = 3'd3;

	localparam logic [1:0] MUL_LO = 2'd0;
	localparam logic [1:0] MUL_HSS = 2'd1;
	localparam logic [1:0] MUL_HSU = 2'd2;
	localparam logic [1:0] MUL_HUU = 2'd3;

	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_LOAD = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [63:0] cur_pc;
		logic [63:0] src1_value;
		logic [63:0] src2_value;
	} in_word_t;

	typedef struct packed {
		logic        rd_write;
		logic [4:0]  rd_index;
		logic [63:0] rd_value;
		logic [63:0] next_pc;
		logic [1:0]  mem_kind;
		logic [1:0]  mem_size;
		logic        mem_unsigned;
		logic [63:0] mem_address;
		logic [63:0] store_data;
		logic        illegal;
	} out_word_t;

	typedef struct packed {
		logic        wr;
		logic [4:0]  rd;
		logic [63:0] value;
		logic [63:0] npc;
		logic [1:0]  kind;
		logic [1:0]  size;
		logic        uns;
		logic [63:0] addr;
		logic [63:0] sdata;
		logic        bad;
		logic        is_mul;
		logic        is_div;
		logic        word;
		logic [1:0]  mul_op;
		logic        div_rem;
		logic        neg_q;
		logic        neg_r;
		logic        div_zero;
	} ctl_t;

endpackage

// ----- rtl/core/rvx_chan.sv -----
// Valid/ready channel that carries one word of type T.
interface rvx_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rvx_div.sv -----
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
module rvx_div import rvx_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [XLEN-1:0] dividend,
	input  logic [XLEN-1:0] divisor,
	output logic [XLEN-1:0] quotient,
	output logic [XLEN-1:0] remainder
);

	typedef struct packed {
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] quo;
	} div_step_t;

	function automatic div_step_t div_step(logic [XLEN-1:0] r, logic [XLEN-1:0] q,
		logic [XLEN-1:0] d);
		logic [XLEN:0] t;
		logic [XLEN:0] diff;
		div_step_t s;
		t = {r, q[XLEN-1]};
		diff = t - {1'b0, d};
		if (!diff[XLEN]) begin
			s.rem = diff[XLEN-1:0];
			s.quo = {q[XLEN-2:0], 1'b1};
		end else begin
			s.rem = t[XLEN-1:0];
			s.quo = {q[XLEN-2:0], 1'b0};
		end
		return s;
	endfunction

	logic [XLEN-1:0] rem_s [DIV_STAGES];
	logic [XLEN-1:0] quo_s [DIV_STAGES];
	logic [XLEN-1:0] den_s [DIV_STAGES];
	div_step_t       step_d [DIV_STAGES];

	always_comb begin
		step_d[0] = div_step('0, dividend, divisor);
		for (int k = 1; k < DIV_STAGES; k++) begin
			step_d[k] = div_step(rem_s[k-1], quo_s[k-1], den_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= divisor;
			rem_s[0] <= step_d[0].rem;
			quo_s[0] <= step_d[0].quo;
			for (int k = 1; k < DIV_STAGES; k++) begin
				den_s[k] <= den_s[k-1];
				rem_s[k] <= step_d[k].rem;
				quo_s[k] <= step_d[k].quo;
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];
	assign remainder = rem_s[DIV_STAGES-1];

endmodule

// ----- rtl/core/rv64im_integer_execute.sv -----
// Top level of the RV64IM integer execute unit.
// Every instruction passes through the whole pipeline from acceptance to its result word.
// One word is accepted per cycle unless the output stalls; the 64-stage divider sets the depth.
// A stalled output freezes the whole pipeline, so no word is lost or repeated.
// Asynchronous active-low reset clears all valid bits; the data path is not reset.
module rv64im_integer_execute import rvx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rvx_chan.sink   req,
	rvx_chan.source rsp
);

	function automatic logic [63:0] alu(logic [2:0] f3, logic alt, logic [63:0] a,
		logic [63:0] b);
		logic [5:0]  sh;
		logic [63:0] r;
		sh = b[5:0];
		unique case (f3)
			F3_ADD: r = alt ? a - b : a + b;
			F3_SLL: r = a << sh;
			F3_SLT: r = {63'd0, $signed(a) < $signed(b)};
			F3_SLTU: r = {63'd0, a < b};
			F3_XOR: r = a ^ b;
			F3_SR: begin
				if (alt) r = $signed(a) >>> sh;
				else r = a >> sh;
			end
			F3_OR: r = a | b;
			default: r = a & b;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] wop(logic [2:0] f3, logic alt, logic [63:0] a,
		logic [63:0] b);
		logic [4:0]  sh;
		logic [31:0] r;
		sh = b[4:0];
		unique case (f3)
			F3_ADD: r = alt ? a[31:0] - b[31:0] : a[31:0] + b[31:0];
			F3_SLL: r = a[31:0] << sh;
			default: begin
				if (alt) r = $signed(a[31:0]) >>> sh;
				else r = a[31:0] >> sh;
			end
		endcase
		return {{32{r[31]}}, r};
	endfunction

	logic adv;
	logic [OUT_STAGE:1] vld_s;

	ctl_t        ctl_d;
	logic [63:0] dva_d, dvb_d;
	ctl_t        ctl_s [1:CTL_STAGES];
	ctl_t        ctl_m;

	logic [63:0]  ma_s1, mb_s1, ma_s2, mb_s2;
	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic [127:0] prod_s2;
	logic [63:0]  dva_s1, dvb_s1;
	logic [63:0]  quo, rmd;
	out_word_t    out_d, out_s66;

	assign adv = !vld_s[OUT_STAGE] || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = vld_s[OUT_STAGE];
	assign rsp.data = out_s66;

	always_comb begin
		logic [31:0] ins;
		logic [63:0] pc, a, b, pc4;
		logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
		logic [6:0]  opc, f7;
		logic [5:0]  f6;
		logic [2:0]  f3;
		logic        take, sgn;
		ins = req.data.instr_word;
		pc = req.data.cur_pc;
		a = req.data.src1_value;
		b = req.data.src2_value;
		opc = ins[6:0];
		f3 = ins[14:12];
		f7 = ins[31:25];
		f6 = ins[31:26];
		imm_i = {{52{ins[31]}}, ins[31:20]};
		imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
		imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		imm_u = {{32{ins[31]}}, ins[31:12], 12'd0};
		pc4 = pc + 64'd4;
		take = 1'b0;

		ctl_d = '0;
		ctl_d.rd = ins[11:7];
		ctl_d.npc = pc4;
		ctl_d.mul_op = f3[1:0];
		ctl_d.div_rem = f3[1];

		unique case (opc)
			OPC_OP: begin
				if (f7 == F7_MULDIV) begin
					ctl_d.wr = 1'b1;
					ctl_d.is_div = f3[2];
					ctl_d.is_mul = !f3[2];
				end else if (f7 == F7_BASE ||
					(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
					ctl_d.value = alu(f3, f7[5], a, b);
					ctl_d.wr = 1'b1;
				end else begin
					ctl_d.bad = 1'b1;
				end
			end
			OPC_OP_IMM: begin
				if (f3 == F3_SLL) ctl_d.bad = (f6 != F6_BASE);
				else if (f3 == F3_SR) ctl_d.bad = (f6 != F6_BASE && f6 != F6_ALT);
				ctl_d.value = alu(f3, f3 == F3_SR && ins[30], a, imm_i);
				ctl_d.wr = 1'b1;
			end
			OPC_OP_32: begin
				ctl_d.word = 1'b1;
				if (f7 == F7_MULDIV) begin
					if (f3 == F3_ADD || f3[2]) begin
						ctl_d.wr = 1'b1;
						ctl_d.is_div = f3[2];
						ctl_d.is_mul = !f3[2];
					end else begin
						ctl_d.bad = 1'b1;
					end
				end else if ((f7 == F7_BASE && (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR))
					|| (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
					ctl_d.value = wop(f3, f7[5], a, b);
					ctl_d.wr = 1'b1;
				end else begin
					ctl_d.bad = 1'b1;
				end
			end
			OPC_OP_IMM_32: begin
				if (f3 == F3_ADD) begin
					ctl_d.value = wop(F3_ADD, 1'b0, a, imm_i);
					ctl_d.wr = 1'b1;
				end else if ((f3 == F3_SLL && f7 == F7_BASE) ||
					(f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT))) begin
					ctl_d.value = wop(f3, f7[5], a, imm_i);
					ctl_d.wr = 1'b1;
				end else begin
					ctl_d.bad = 1'b1;
				end
			end
			OPC_LUI: begin
				ctl_d.value = imm_u;
				ctl_d.wr = 1'b1;
			end
			OPC_AUIPC: begin
				ctl_d.value = pc + imm_u;
				ctl_d.wr = 1'b1;
			end
			OPC_JAL: begin
				ctl_d.value = pc4;
				ctl_d.wr = 1'b1;
				ctl_d.npc = pc + imm_j;
			end
			OPC_JALR: begin
				if (f3 != 3'd0) begin
					ctl_d.bad = 1'b1;
				end else begin
					ctl_d.value = pc4;
					ctl_d.wr = 1'b1;
					ctl_d.npc = (a + imm_i) & ~64'd1;
				end
			end
			OPC_BRANCH: begin
				unique case (f3)
					F3_BEQ: take = (a == b);
					F3_BNE: take = (a != b);
					F3_BLT: take = $signed(a) < $signed(b);
					F3_BGE: take = !($signed(a) < $signed(b));
					F3_BLTU: take = (a < b);
					F3_BGEU: take = (a >= b);
					default: ctl_d.bad = 1'b1;
				endcase
				if (take) ctl_d.npc = pc + imm_b;
			end
			OPC_LOAD: begin
				if (f3 == F3_LOAD_BAD) begin
					ctl_d.bad = 1'b1;
				end else begin
					ctl_d.kind = MEM_LOAD;
					ctl_d.size = f3[1:0];
					ctl_d.uns = f3[2];
					ctl_d.addr = a + imm_i;
				end
			end
			OPC_STORE: begin
				if (f3 > F3_STORE_MAX) begin
					ctl_d.bad = 1'b1;
				end else begin
					ctl_d.kind = MEM_STORE;
					ctl_d.size = f3[1:0];
					ctl_d.addr = a + imm_s;
					ctl_d.sdata = b;
				end
			end
			default: ctl_d.bad = 1'b1;
		endcase

		if (ctl_d.bad) begin
			ctl_d.wr = 1'b0;
			ctl_d.npc = pc4;
			ctl_d.kind = MEM_NONE;
			ctl_d.size = 2'd0;
			ctl_d.uns = 1'b0;
			ctl_d.addr = '0;
			ctl_d.sdata = '0;
			ctl_d.is_mul = 1'b0;
			ctl_d.is_div = 1'b0;
		end
		if (!ctl_d.wr || ctl_d.rd == 5'd0) begin
			ctl_d.wr = 1'b0;
			ctl_d.value = '0;
		end

		sgn = !f3[0];
		if (ctl_d.word) begin
			dva_d = sgn ? {{32{a[31]}}, a[31:0]} : {32'd0, a[31:0]};
			dvb_d = sgn ? {{32{b[31]}}, b[31:0]} : {32'd0, b[31:0]};
		end else begin
			dva_d = a;
			dvb_d = b;
		end
		ctl_d.neg_q = sgn && (dva_d[63] ^ dvb_d[63]);
		ctl_d.neg_r = sgn && dva_d[63];
		ctl_d.div_zero = (dvb_d == 64'd0);
		if (sgn && dva_d[63]) dva_d = 64'd0 - dva_d;
		if (sgn && dvb_d[63]) dvb_d = 64'd0 - dvb_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1 <= req.data.src1_value;
			mb_s1 <= req.data.src2_value;
			p00_s1 <= req.data.src1_value[31:0] * req.data.src2_value[31:0];
			p01_s1 <= req.data.src1_value[31:0] * req.data.src2_value[63:32];
			p10_s1 <= req.data.src1_value[63:32] * req.data.src2_value[31:0];
			p11_s1 <= req.data.src1_value[63:32] * req.data.src2_value[63:32];
			dva_s1 <= dva_d;
			dvb_s1 <= dvb_d;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			prod_s2 <= {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
				+ {p11_s1, 64'd0};
		end
	end

	always_comb begin
		logic [63:0] hi, mres;
		hi = prod_s2[127:64];
		unique case (ctl_s[2].mul_op)
			MUL_LO: begin
				if (ctl_s[2].word) mres = {{32{prod_s2[31]}}, prod_s2[31:0]};
				else mres = prod_s2[63:0];
			end
			MUL_HSS: mres = hi - (ma_s2[63] ? mb_s2 : 64'd0) - (mb_s2[63] ? ma_s2 : 64'd0);
			MUL_HSU: mres = hi - (ma_s2[63] ? mb_s2 : 64'd0);
			default: mres = hi;
		endcase
		ctl_m = ctl_s[2];
		if (ctl_s[2].is_mul && ctl_s[2].wr) ctl_m.value = mres;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[1] <= ctl_d;
			ctl_s[2] <= ctl_s[1];
			ctl_s[3] <= ctl_m;
			for (int k = 4; k <= CTL_STAGES; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
			out_s66 <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[OUT_STAGE-1:1], req.valid};
		end
	end

	rvx_div u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (dva_s1),
		.divisor  (dvb_s1),
		.quotient (quo),
		.remainder(rmd)
	);

	always_comb begin
		ctl_t        c;
		logic [63:0] dres;
		c = ctl_s[CTL_STAGES];
		if (c.div_rem) dres = c.neg_r ? 64'd0 - rmd : rmd;
		else if (c.div_zero) dres = '1;
		else dres = c.neg_q ? 64'd0 - quo : quo;
		if (c.word) dres = {{32{dres[31]}}, dres[31:0]};
		out_d.rd_write = c.wr;
		out_d.rd_index = c.rd;
		out_d.rd_value = (c.is_div && c.wr) ? dres : c.value;
		out_d.next_pc = c.npc;
		out_d.mem_kind = c.kind;
		out_d.mem_size = c.size;
		out_d.mem_unsigned = c.uns;
		out_d.mem_address = c.addr;
		out_d.store_data = c.sdata;
		out_d.illegal = c.bad;
	end

`ifndef SYNTHESIS
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.illegal |-> !rsp.data.rd_write && rsp.data.mem_kind == MEM_NONE)
		else $error("illegal word requests a write or memory access");
	a_no_x0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.rd_write |-> rsp.data.rd_index != 5'd0)
		else $error("write to x0 requested");
	a_mem_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.mem_kind != MEM_NONE |-> !rsp.data.rd_write)
		else $error("memory access also writes back");
	a_mem_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.mem_kind != 2'd3)
		else $error("undefined memory kind");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during a stall");
`endif

endmodule
